// ----- rtl/core/obmt_pkg.sv -----
`default_nettype none

package obmt_pkg;

	localparam int MAX_BOXES  = 64;
	localparam int COORD_BITS = 12;
	localparam int IDX_W      = $clog2(MAX_BOXES);
	localparam int CNT_W      = $clog2(MAX_BOXES + 1);
	localparam int AREA_W     = 2 * COORD_BITS;

	localparam logic KIND_OFFER = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
	} box_t;

	// result of comparing an offered/candidate box against one stored entry
	typedef struct packed {
		logic overlap;
		logic larger;
		logic same;
	} cmp_t;

endpackage

`default_nettype wire

// ----- rtl/core/obmt_box_cmp.sv -----
`default_nettype none

module obmt_box_cmp import obmt_pkg::*; (
	input  wire box_t                a,
	input  wire logic [AREA_W-1:0]   a_area,
	input  wire box_t                b,
	output cmp_t                     res
);

	logic [COORD_BITS:0] ax2, bx2, ay2, by2;
	logic [COORD_BITS:0] x1, x2, y1, y2;
	logic [AREA_W-1:0]   b_area;

	always_comb begin
		ax2 = {1'b0, a.x} + {1'b0, a.w};
		bx2 = {1'b0, b.x} + {1'b0, b.w};
		ay2 = {1'b0, a.y} + {1'b0, a.h};
		by2 = {1'b0, b.y} + {1'b0, b.h};
		x1  = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
		y1  = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
		x2  = (ax2 < bx2) ? ax2 : bx2;
		y2  = (ay2 < by2) ? ay2 : by2;
		b_area = b.w * b.h;
		res.overlap = (x2 > x1) && (y2 > y1);
		res.larger  = a_area > b_area;
		res.same    = (a == b);
	end

endmodule

`default_nettype wire

// ----- rtl/core/overlap_box_merge_table_core.sv -----
// Offer: into an empty table the box is written straight to entry 0; otherwise every
// table entry is read, one per cycle, through the single read port of the box memory.
// Flush: on an empty table it goes straight to the final output; otherwise each entry i
// is checked against all earlier entries, one read per cycle, and output stalls can hold it.
// One item at a time; in_ready is high only when no item is in progress.
// Reset clears the entry count, overflow flag and output valid; box memory is not cleared.
`default_nettype none

module overlap_box_merge_table_core import obmt_pkg::*; (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              in_valid,
	output logic                    in_ready,
	input  wire  logic              kind,
	input  wire  logic [COORD_BITS-1:0] box_x,
	input  wire  logic [COORD_BITS-1:0] box_y,
	input  wire  logic [COORD_BITS-1:0] box_w,
	input  wire  logic [COORD_BITS-1:0] box_h,
	output logic                    out_valid,
	input  wire  logic              out_ready,
	output logic [COORD_BITS-1:0]   out_x,
	output logic [COORD_BITS-1:0]   out_y,
	output logic [COORD_BITS-1:0]   out_w,
	output logic [COORD_BITS-1:0]   out_h,
	output logic                    box_valid,
	output logic                    last_box,
	output logic                    overflowed
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_OSCAN = 3'd1;
	localparam logic [2:0] S_FI    = 3'd2;
	localparam logic [2:0] S_FC    = 3'd3;
	localparam logic [2:0] S_FJ    = 3'd4;
	localparam logic [2:0] S_FE    = 3'd5;
	localparam logic [2:0] S_FL    = 3'd6;

	box_t mem [MAX_BOXES];
	box_t rdata_q;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  sc_q;
	logic [CNT_W-1:0]  i_q;
	logic              pend_q;
	logic [IDX_W-1:0]  pidx_q;
	logic              hit_q;
	logic              seen_q;
	logic              hold_bv_q;
	logic              ov_q;

	box_t              nb_q;
	logic [AREA_W-1:0] na_q;
	box_t              cand_q;
	box_t              hold_q;
	box_t              obox_q;
	logic              obv_q;
	logic              olast_q;
	logic              oovf_q;

	box_t              in_box;
	box_t              ref_box;
	box_t              wdata;
	cmp_t              cmp;
	logic              acc;
	logic              slot_free;
	logic              scan_go;
	logic [CNT_W-1:0]  limit;
	logic [CNT_W-1:0]  i_nxt;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [IDX_W-1:0]  raddr;
	logic              push;
	logic              push_last;
	logic              fe_adv;
	logic              o_done;
	logic              full;

	assign in_box    = '{x: box_x, y: box_y, w: box_w, h: box_h};
	assign in_ready  = (state_q == S_IDLE);
	assign acc       = in_valid && in_ready;
	assign slot_free = !ov_q || out_ready;
	assign ref_box   = (state_q == S_OSCAN) ? nb_q : cand_q;
	assign limit     = (state_q == S_OSCAN) ? count_q : i_q;
	assign scan_go   = sc_q < limit;
	assign i_nxt     = i_q + CNT_W'(1);
	assign full      = count_q >= CNT_W'(MAX_BOXES);
	assign o_done    = !scan_go && !pend_q;
	assign fe_adv    = seen_q || !hold_bv_q || slot_free;

	obmt_box_cmp u_cmp (
		.a      (ref_box),
		.a_area (na_q),
		.b      (rdata_q),
		.res    (cmp)
	);

	always_comb begin
		raddr     = '0;
		we        = 1'b0;
		waddr     = '0;
		wdata     = nb_q;
		push      = 1'b0;
		push_last = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				// first box into an empty table goes straight to entry 0
				if (acc && kind == KIND_OFFER && count_q == '0) begin
					we    = 1'b1;
					wdata = in_box;
				end
			end
			S_OSCAN: begin
				raddr = sc_q[IDX_W-1:0];
				if (pend_q && cmp.overlap && cmp.larger) begin
					we    = 1'b1;
					waddr = pidx_q;
				end else if (o_done && !hit_q && !full) begin
					we    = 1'b1;
					waddr = count_q[IDX_W-1:0];
				end
			end
			S_FI: begin
				raddr = i_q[IDX_W-1:0];
			end
			S_FC: begin
			end
			S_FJ: begin
				raddr = sc_q[IDX_W-1:0];
			end
			S_FE: begin
				push = !seen_q && hold_bv_q && slot_free;
			end
			S_FL: begin
				push      = slot_free;
				push_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			sc_q      <= '0;
			i_q       <= '0;
			pend_q    <= 1'b0;
			pidx_q    <= '0;
			hit_q     <= 1'b0;
			seen_q    <= 1'b0;
			hold_bv_q <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (push) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (kind == KIND_FLUSH) begin
							hold_bv_q <= 1'b0;
							i_q       <= '0;
							state_q   <= (count_q == '0) ? S_FL : S_FI;
						end else if (count_q == '0) begin
							count_q <= CNT_W'(1);
						end else begin
							sc_q    <= '0;
							pend_q  <= 1'b0;
							hit_q   <= 1'b0;
							state_q <= S_OSCAN;
						end
					end
				end
				S_OSCAN: begin
					if (scan_go) begin
						sc_q <= sc_q + CNT_W'(1);
					end
					pend_q <= scan_go;
					pidx_q <= sc_q[IDX_W-1:0];
					if (pend_q && (cmp.overlap || cmp.same)) begin
						hit_q <= 1'b1;
					end
					if (o_done) begin
						if (!hit_q) begin
							if (full) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						state_q <= S_IDLE;
					end
				end
				S_FI: begin
					state_q <= S_FC;
				end
				S_FC: begin
					sc_q    <= '0;
					pend_q  <= 1'b0;
					seen_q  <= 1'b0;
					state_q <= S_FJ;
				end
				S_FJ: begin
					if (scan_go) begin
						sc_q <= sc_q + CNT_W'(1);
					end
					pend_q <= scan_go;
					if (pend_q && cmp.same) begin
						seen_q <= 1'b1;
					end
					if (o_done) begin
						state_q <= S_FE;
					end
				end
				S_FE: begin
					// the held box goes out only once a later distinct box shows it is not last
					if (fe_adv) begin
						if (!seen_q) begin
							hold_bv_q <= 1'b1;
						end
						i_q     <= i_nxt;
						state_q <= (i_nxt == count_q) ? S_FL : S_FI;
					end
				end
				S_FL: begin
					if (slot_free) begin
						count_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			nb_q <= in_box;
			na_q <= box_w * box_h;
			if (kind == KIND_FLUSH) begin
				hold_q <= '0;
			end
		end
		if (state_q == S_FC) begin
			cand_q <= rdata_q;
		end
		if (state_q == S_FE && fe_adv && !seen_q) begin
			hold_q <= cand_q;
		end
		if (push) begin
			obox_q  <= hold_q;
			obv_q   <= hold_bv_q;
			olast_q <= push_last;
			oovf_q  <= ovf_q;
		end
	end

	assign out_valid  = ov_q;
	assign out_x      = obox_q.x;
	assign out_y      = obox_q.y;
	assign out_w      = obox_q.w;
	assign out_h      = obox_q.h;
	assign box_valid  = obv_q;
	assign last_box   = olast_q;
	assign overflowed = oovf_q;

endmodule

`default_nettype wire
